[rtl/core/lpre_pkg.sv]
// shared types and constants for the life pattern rle encoder
// used by the front, queue, back and top level modules
package lpre_pkg;

    localparam int GRID_SIDE = 4096;
    localparam int CNT_W     = 13;
    localparam int COL_W     = 9;
    localparam int CFG_W     = 8;
    localparam int SLOTS     = 4;
    localparam int Q_DEPTH   = 4;
    localparam int Q_AW      = 2;

    // run and row-break counts saturate at the grid side or at the count field limit
    localparam logic [CNT_W-1:0] RUN_CAP =
        (GRID_SIDE < 8191) ? CNT_W'(GRID_SIDE) : CNT_W'(8191);

    localparam logic [CFG_W-1:0] MAX_COL_RESET = 8'd70;
    localparam logic [CNT_W-1:0] CNT_ONE       = 13'd1;
    localparam logic [CNT_W-1:0] CNT_TWO_DIGIT = 13'd9;
    localparam logic [COL_W-1:0] COL_ONE       = 9'd1;
    localparam logic [COL_W-1:0] COL_TWO       = 9'd2;
    localparam logic [COL_W-1:0] COL_THREE     = 9'd3;

    // configuration register indexes
    localparam int REG_MAX_LINE_COLUMNS = 0;

    // cell codes
    localparam logic [1:0] CELL_OFF     = 2'd0;
    localparam logic [1:0] CELL_UNKNOWN = 2'd2;
    localparam logic [1:0] CELL_SPARE   = 2'd3;

    // token slots within one packet, in emission order
    localparam int SLOT_BREAK = 0;
    localparam int SLOT_PREV  = 1;
    localparam int SLOT_ROW   = 2;
    localparam int SLOT_END   = 3;

    typedef enum logic [2:0] {
        SYM_OFF     = 3'd0,
        SYM_ON      = 3'd1,
        SYM_UNKNOWN = 3'd2,
        SYM_BREAK   = 3'd3,
        SYM_END     = 3'd4
    } t_sym;

    typedef struct packed {
        t_sym             sym;
        logic [CNT_W-1:0] cnt;
    } t_tok;

    typedef struct packed {
        logic [SLOTS-1:0] vld;
        t_tok [SLOTS-1:0] tok;
    } t_pkt;

    typedef struct packed {
        logic push;
        t_pkt pkt;
    } t_q_wr;

    typedef struct packed {
        logic nonempty;
        logic full;
        t_pkt pkt;
    } t_q_rd;

endpackage

[rtl/core/lpre_front.sv]
// front end: accepts cells, tracks runs and row breaks, builds token packets
// depends on lpre_pkg
module lpre_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [1:0]     i_cell,
    input  logic           i_row_start,
    input  logic           i_row_end,
    input  logic           i_pat_end,
    input  logic           i_q_full,
    output lpre_pkg::t_q_wr o_wr
);
    import lpre_pkg::*;

    logic [1:0]       r_prev,    n_prev;
    logic [CNT_W-1:0] r_rl,      n_rl;
    logic [CNT_W-1:0] r_pend,    n_pend;
    logic             r_started, n_started;

    logic             acc;
    logic [1:0]       cs;
    logic [1:0]       prev1;
    logic [CNT_W-1:0] rl1, rl2, pend1;
    logic             diff;
    t_pkt             pkt;

    assign o_ready = !i_q_full;
    assign acc     = i_valid && o_ready;

    always_comb begin
        cs = (i_cell == CELL_SPARE) ? CELL_UNKNOWN : i_cell;

        prev1 = r_prev;
        rl1   = r_rl;
        pend1 = r_pend;
        if (i_row_start || !r_started) begin
            rl1 = '0;
        end
        if (!r_started) begin
            pend1 = '0;
            prev1 = cs;
        end

        pkt    = '0;
        n_pend = pend1;
        diff   = (prev1 != cs);

        pkt.tok[SLOT_BREAK].sym = SYM_BREAK;
        pkt.tok[SLOT_BREAK].cnt = pend1;
        pkt.tok[SLOT_PREV].sym  = t_sym'({1'b0, prev1});
        pkt.tok[SLOT_PREV].cnt  = rl1;

        if (diff && cs != CELL_OFF && pend1 != '0) begin
            pkt.vld[SLOT_BREAK] = 1'b1;
            n_pend = '0;
        end
        if (diff && rl1 != '0) begin
            pkt.vld[SLOT_PREV] = 1'b1;
        end

        rl2 = diff ? '0 : rl1;
        if (rl2 < RUN_CAP) begin
            rl2 = rl2 + CNT_ONE;
        end
        n_rl   = rl2;
        n_prev = cs;

        pkt.tok[SLOT_ROW].sym = t_sym'({1'b0, cs});
        pkt.tok[SLOT_ROW].cnt = rl2;
        // pattern end closes the row as well
        if (i_row_end || i_pat_end) begin
            if (n_pend < RUN_CAP) begin
                n_pend = n_pend + CNT_ONE;
            end
            if (cs != CELL_OFF) begin
                pkt.vld[SLOT_ROW] = 1'b1;
            end
            n_prev = CELL_OFF;
            n_rl   = '0;
        end

        pkt.tok[SLOT_END].sym = SYM_END;
        pkt.tok[SLOT_END].cnt = CNT_ONE;
        n_started = 1'b1;
        if (i_pat_end) begin
            pkt.vld[SLOT_END] = 1'b1;
            n_prev    = CELL_OFF;
            n_rl      = '0;
            n_pend    = '0;
            n_started = 1'b0;
        end

        o_wr.push = acc && (pkt.vld != '0);
        o_wr.pkt  = pkt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev    <= CELL_OFF;
            r_rl      <= '0;
            r_pend    <= '0;
            r_started <= 1'b0;
        end else if (acc) begin
            r_prev    <= n_prev;
            r_rl      <= n_rl;
            r_pend    <= n_pend;
            r_started <= n_started;
        end
    end

endmodule

[rtl/core/lpre_queue.sv]
// short packet queue between the front and back ends
// depends on lpre_pkg
module lpre_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lpre_pkg::t_q_wr i_wr,
    input  logic            i_pop,
    output lpre_pkg::t_q_rd o_rd
);
    import lpre_pkg::*;

    t_pkt             r_mem [Q_DEPTH];
    logic [Q_AW-1:0]  r_wp, r_rp;
    logic [Q_AW:0]    r_cnt, n_cnt;

    always_comb begin
        n_cnt = r_cnt;
        if (i_wr.push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_wr.push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
        o_rd.nonempty = (r_cnt != '0);
        o_rd.full     = (r_cnt == (Q_AW+1)'(Q_DEPTH));
        o_rd.pkt      = r_mem[r_rp];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.push) begin
            r_mem[r_wp] <= i_wr.pkt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_wr.push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

endmodule

[rtl/core/lpre_back.sv]
// back end: walks the token slots of each packet, tracks text columns,
// drives the output register; depends on lpre_pkg
module lpre_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lpre_pkg::t_q_rd             i_rd,
    output logic                        o_pop,
    input  logic [lpre_pkg::CFG_W-1:0]  i_max_col,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [2:0]                  o_symbol,
    output logic [lpre_pkg::CNT_W-1:0]  o_count,
    output logic                        o_wrap,
    output logic                        o_last
);
    import lpre_pkg::*;

    logic [SLOTS-1:0] r_done, n_done;
    logic [COL_W-1:0] r_col,  n_col;
    logic             r_valid;
    t_sym             r_sym;
    logic [CNT_W-1:0] r_cnt;
    logic             r_wrap, r_last;

    logic [SLOTS-1:0] pend, pick, rest;
    t_tok             tok;
    logic             load, wrap, last;
    logic [COL_W-1:0] add, sum;

    always_comb begin
        pend = i_rd.pkt.vld & ~r_done;
        pick = '0;
        tok  = i_rd.pkt.tok[0];
        for (int k = SLOTS - 1; k >= 0; k--) begin
            if (pend[k]) begin
                pick = '0;
                pick[k] = 1'b1;
                tok  = i_rd.pkt.tok[k];
            end
        end
        rest = pend & ~pick;
        last = (rest == '0);
        load = i_rd.nonempty && (!r_valid || i_ready);

        if (tok.cnt == CNT_ONE) begin
            add = COL_ONE;
        end else if (tok.cnt > CNT_TWO_DIGIT) begin
            add = COL_THREE;
        end else begin
            add = COL_TWO;
        end
        sum = r_col + add;

        // end token always wraps and starts the next pattern at column zero
        if (tok.sym == SYM_END) begin
            wrap  = 1'b1;
            n_col = '0;
        end else begin
            wrap  = (sum > {1'b0, i_max_col});
            n_col = wrap ? '0 : sum;
        end

        n_done = last ? '0 : (r_done | pick);
        o_pop  = load && last;
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_sym  <= tok.sym;
            r_cnt  <= tok.cnt;
            r_wrap <= wrap;
            r_last <= last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_done  <= '0;
            r_col   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_done  <= n_done;
                r_col   <= n_col;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid  = r_valid;
    assign o_symbol = r_sym;
    assign o_count  = r_cnt;
    assign o_wrap   = r_wrap;
    assign o_last   = r_last;

endmodule

[rtl/core/life_pattern_rle_encoder.sv]
// top level of the life pattern rle encoder: apb register, front, queue, back
// depends on lpre_pkg, lpre_front, lpre_queue and lpre_back
// the first token of a cell passes through the packet queue, then the output register
// throughput: one cell per cycle unless the queue is full; the output register
//   sends one token per cycle unless m_axis_tready stalls it, behind a four-packet queue
// reset (synchronous, active low) clears run state, queue, columns and sets max columns to 70
module life_pattern_rle_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [1:0] cell_state, [7:2] zero
    input  logic [1:0]  s_axis_tuser,   // [0] row_start, [1] row_end
    input  logic        s_axis_tlast,   // pattern_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [2:0] symbol, [15:3] run_count
    output logic [0:0]  m_axis_tuser,   // [0] wrap_after
    output logic        m_axis_tlast,   // last_of_run
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lpre_pkg::*;

    localparam logic [2:0] ADDR_MAX_COL = 3'(4 * REG_MAX_LINE_COLUMNS);

    logic [CFG_W-1:0] r_max_col;
    logic             cfg_wr;
    t_q_wr            q_wr;
    t_q_rd            q_rd;
    logic             q_pop;
    logic [2:0]       sym;
    logic [CNT_W-1:0] cnt;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_MAX_COL);
    assign prdata = (paddr == ADDR_MAX_COL) ? {24'd0, r_max_col} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_col <= MAX_COL_RESET;
        end else if (cfg_wr) begin
            r_max_col <= pwdata[CFG_W-1:0];
        end
    end

    lpre_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_cell      (s_axis_tdata[1:0]),
        .i_row_start (s_axis_tuser[0]),
        .i_row_end   (s_axis_tuser[1]),
        .i_pat_end   (s_axis_tlast),
        .i_q_full    (q_rd.full),
        .o_wr        (q_wr)
    );

    lpre_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_pop   (q_pop),
        .o_rd    (q_rd)
    );

    lpre_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd      (q_rd),
        .o_pop     (q_pop),
        .i_max_col (r_max_col),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_symbol  (sym),
        .o_count   (cnt),
        .o_wrap    (m_axis_tuser[0]),
        .o_last    (m_axis_tlast)
    );

    assign m_axis_tdata = {cnt, sym};

endmodule
